// ===== src/leg_inverse_kinematics_defines.svh =====
// Assertion macros for the leg inverse kinematics block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef LEG_INVERSE_KINEMATICS_DEFINES_SVH
`define LEG_INVERSE_KINEMATICS_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define LIK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("leg_ik assertion failed");
// Property whose consequent must hold in the cycle after the antecedent.
`define LIK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("leg_ik assertion failed");
`else
`define LIK_ASSERT(lbl, clk, rst_n, prop)
`define LIK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/leg_ik_pkg.sv =====
// Shared types, constants and tables of the leg inverse kinematics block.
// No dependencies; used by the interfaces, the CORDIC unit and the top level.
`default_nettype none
package leg_ik_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEMUR    = 3'd0,
    CFG_TIBIA    = 3'd1,
    CFG_YAW_MIN  = 3'd2,
    CFG_YAW_MAX  = 3'd3,
    CFG_KNEE_MIN = 3'd4,
    CFG_KNEE_MAX = 3'd5
  } cfg_idx_e;

  localparam logic [15:0]        FEMUR_RST    = 16'd3604;
  localparam logic [15:0]        TIBIA_RST    = 16'd4260;
  localparam logic signed [15:0] YAW_MIN_RST  = -16'sd4293;
  localparam logic signed [15:0] YAW_MAX_RST  = 16'sd5718;
  localparam logic [14:0]        KNEE_MIN_RST = 15'd1434;
  localparam logic [14:0]        KNEE_MAX_RST = 15'd18579;

  localparam int COORD_W = 18;
  localparam int ANGLE_W = 16;
  localparam int KNEE_W  = 15;
  localparam int ANKLE_W = 15;

  // CORDIC datapath
  localparam int CW           = 32;
  localparam int ACC_W        = 21;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam logic signed [ACC_W-1:0]   ANG_PI    = 21'sd205887;
  localparam logic signed [ACC_W-1:0]   ANG_HALF  = 21'sd4;
  localparam logic signed [ACC_W-1:0]   Q13_PI_A  = 21'sd25736;
  localparam logic signed [ANGLE_W-1:0] Q13_PI    = 16'sd25736;

  // Knee cosine divider and square roots
  localparam int DIV_STEPS  = 28;
  localparam int DEN_W      = 33;
  localparam int SQRT_STEPS = 29;
  localparam int SQ_VW      = 57;

  typedef struct packed {
    logic kzero;
    logic kpi;
    logic neg;
  } kflag_t;

  function automatic logic signed [ACC_W-1:0] atan_entry(input int unsigned i);
    case (i)
      0:       return 21'sd51472;
      1:       return 21'sd30386;
      2:       return 21'sd16055;
      3:       return 21'sd8150;
      4:       return 21'sd4091;
      5:       return 21'sd2047;
      6:       return 21'sd1024;
      7:       return 21'sd512;
      8:       return 21'sd256;
      9:       return 21'sd128;
      10:      return 21'sd64;
      11:      return 21'sd32;
      12:      return 21'sd16;
      13:      return 21'sd8;
      14:      return 21'sd4;
      15:      return 21'sd2;
      default: return '0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== src/leg_ik_target_if.sv =====
// Request channel carrying one foot target.
// Depends on leg_ik_pkg for the coordinate width.
`default_nettype none
interface leg_ik_target_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [leg_ik_pkg::COORD_W-1:0]      target_x;
  logic signed [leg_ik_pkg::COORD_W-1:0]      target_y;
  logic signed [leg_ik_pkg::COORD_W-1:0]      target_z;

  modport source (output valid, output target_x, output target_y, output target_z,
                  input ready);
  modport sink (input valid, input target_x, input target_y, input target_z,
                output ready);
endinterface
`default_nettype wire

// ===== src/leg_ik_joint_if.sv =====
// Result channel carrying the four joint angles of one request.
// Depends on leg_ik_pkg for the angle widths.
`default_nettype none
interface leg_ik_joint_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [leg_ik_pkg::ANGLE_W-1:0]      hip_yaw;
  logic signed [leg_ik_pkg::ANGLE_W-1:0]      pitch_angle;
  logic        [leg_ik_pkg::KNEE_W-1:0]       knee;
  logic signed [leg_ik_pkg::ANKLE_W-1:0]      ankle;

  modport source (output valid, output hip_yaw, output pitch_angle, output knee,
                  output ankle, input ready);
  modport sink (input valid, input hip_yaw, input pitch_angle, input knee,
                input ankle, output ready);
endinterface
`default_nettype wire

// ===== src/leg_ik_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(y, x) in Q3.13, saturated to +/-pi.
// Depends on leg_ik_pkg for widths and the arctangent table.
`default_nettype none
module leg_ik_cordic (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [leg_ik_pkg::CW-1:0]       x_i,
  input  logic signed [leg_ik_pkg::CW-1:0]       y_i,
  output logic signed [leg_ik_pkg::ANGLE_W-1:0]  angle_o
);
  import leg_ik_pkg::*;

  logic signed [CW-1:0]      cx_q [0:CORDIC_STEPS-1];
  logic signed [CW-1:0]      cy_q [0:CORDIC_STEPS-1];
  logic signed [ACC_W-1:0]   ca_q [0:CORDIC_STEPS];
  logic                      zy_q [0:CORDIC_STEPS];
  logic                      xn_q [0:CORDIC_STEPS];
  logic signed [ACC_W-1:0]   a_rnd;
  logic signed [ANGLE_W-1:0] angle_d, angle_q;

  // Fold the left half plane onto the right one.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zy_q[0] <= (y_i == '0);
      xn_q[0] <= x_i[CW-1];
      if (x_i[CW-1]) begin
        cx_q[0] <= -x_i;
        cy_q[0] <= -y_i;
        ca_q[0] <= y_i[CW-1] ? -ANG_PI : ANG_PI;
      end else begin
        cx_q[0] <= x_i;
        cy_q[0] <= y_i;
        ca_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zy_q[i+1] <= zy_q[i];
        xn_q[i+1] <= xn_q[i];
        if (!cy_q[i][CW-1]) begin
          ca_q[i+1] <= ca_q[i] + atan_entry(i);
        end else begin
          ca_q[i+1] <= ca_q[i] - atan_entry(i);
        end
      end
    end
    // The last rotation only moves the angle, so its x and y are not kept.
    if (i < CORDIC_STEPS - 1) begin : g_xy
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!cy_q[i][CW-1]) begin
            cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
            cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          end else begin
            cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
            cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          end
        end
      end
    end
  end

  // Round to Q3.13 and saturate; a zero ordinate gives 0 or pi directly.
  assign a_rnd = (ca_q[CORDIC_STEPS] + ANG_HALF) >>> 3;

  always_comb begin
    if (zy_q[CORDIC_STEPS]) begin
      angle_d = xn_q[CORDIC_STEPS] ? Q13_PI : '0;
    end else if (a_rnd > Q13_PI_A) begin
      angle_d = Q13_PI;
    end else if (a_rnd < -Q13_PI_A) begin
      angle_d = -Q13_PI;
    end else begin
      angle_d = a_rnd[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o = angle_q;

endmodule
`default_nettype wire

// ===== src/leg_inverse_kinematics.sv =====
// Top level of the leg inverse kinematics block: squares, divider, square roots, CORDICs.
// Depends on leg_ik_pkg, the two channel interfaces, leg_ik_cordic and the defines header.
//
// Usage: a foot target (x, y, z, LSB 2^-16 m) is offered on tgt_i; the hip yaw, hip pitch,
// knee and ankle angles (Q3.13 radians) of that request leave on jnt_o, one result for
// each request and in the same order. Link lengths and joint limits sit on the plain
// write port cfg_*, one register per write, and are meant to be changed only while no
// request is in flight.
// The longest path is the knee: a 28-step restoring divider for the cosine, a 29-step
// square root for the sine and an 18-stage CORDIC. Yaw and pitch are delayed to line
// up with it. Throughput is one request per cycle while the receiver does not stall:
// every stage is a register rank with its own valid bit and the whole pipeline moves
// on a single enable. When the receiver stalls with a result waiting, the enable drops,
// every rank holds and tgt_i.ready goes low; nothing is lost or repeated. While the last
// rank is empty the pipeline keeps moving, so bubbles drain even under a stall.
// Reset clears all valid bits and loads the configuration registers with their defaults.
`default_nettype none
`include "leg_inverse_kinematics_defines.svh"
module leg_inverse_kinematics (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  leg_ik_target_if.sink                          tgt_i,
  leg_ik_joint_if.source                         jnt_o,
  input  logic                                   cfg_we_i,
  input  logic [leg_ik_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [leg_ik_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import leg_ik_pkg::*;

  // Register rank at which each intermediate becomes available.
  localparam int R_PL = 2 + SQRT_STEPS;        // planar distance
  localparam int R_Q  = 4 + DIV_STEPS;         // cosine quotient
  localparam int R_QQ = R_Q + 1;               // quotient squared
  localparam int R_S  = R_QQ + SQRT_STEPS;     // sine
  localparam int R_Y  = 1 + CORDIC_LAT;        // raw yaw
  localparam int R_P  = R_PL + CORDIC_LAT;     // pitch
  localparam int R_K  = R_S + CORDIC_LAT;      // raw knee
  localparam int LAT  = R_K + 1;               // output register

  // ---------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------
  logic [15:0]        femur_q, tibia_q;
  logic signed [15:0] yaw_min_q, yaw_max_q;
  logic [14:0]        knee_min_q, knee_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      femur_q    <= FEMUR_RST;
      tibia_q    <= TIBIA_RST;
      yaw_min_q  <= YAW_MIN_RST;
      yaw_max_q  <= YAW_MAX_RST;
      knee_min_q <= KNEE_MIN_RST;
      knee_max_q <= KNEE_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FEMUR:    femur_q    <= cfg_wdata_i;
        CFG_TIBIA:    tibia_q    <= cfg_wdata_i;
        CFG_YAW_MIN:  yaw_min_q  <= $signed(cfg_wdata_i);
        CFG_YAW_MAX:  yaw_max_q  <= $signed(cfg_wdata_i);
        CFG_KNEE_MIN: knee_min_q <= cfg_wdata_i[KNEE_W-1:0];
        CFG_KNEE_MAX: knee_max_q <= cfg_wdata_i[KNEE_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------------
  // Pipeline control: one enable for every rank, valid bits travel with the data.
  // ---------------------------------------------------------------------------------
  logic           en;
  logic [LAT:1]   vld_q;

  assign en          = !vld_q[LAT] || jnt_o.ready;
  assign tgt_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-1:1], tgt_i.valid};
    end
  end

  // ---------------------------------------------------------------------------------
  // Ranks 1 to 3: squares and the law of cosines numerator and denominator.
  // reach^2 and the link terms are exact integers.
  // ---------------------------------------------------------------------------------
  logic signed [COORD_W-1:0] x1_q, y1_q, z1_q;
  logic signed [35:0]        xx1_q, yy1_q, zz1_q;
  logic [31:0]               ff1_q, tt1_q, ft1_q;
  logic [35:0]               pl2_2_q, zz2_q;
  logic [DEN_W-1:0]          fftt2_q, den2_q, den3_q;
  logic signed [38:0]        num3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q    <= tgt_i.target_x;
      y1_q    <= tgt_i.target_y;
      z1_q    <= tgt_i.target_z;
      xx1_q   <= 36'(tgt_i.target_x) * 36'(tgt_i.target_x);
      yy1_q   <= 36'(tgt_i.target_y) * 36'(tgt_i.target_y);
      zz1_q   <= 36'(tgt_i.target_z) * 36'(tgt_i.target_z);
      ff1_q   <= 32'(femur_q) * 32'(femur_q);
      tt1_q   <= 32'(tibia_q) * 32'(tibia_q);
      ft1_q   <= 32'(femur_q) * 32'(tibia_q);

      pl2_2_q <= xx1_q + yy1_q;
      zz2_q   <= zz1_q;
      fftt2_q <= DEN_W'(ff1_q) + DEN_W'(tt1_q);
      den2_q  <= {ft1_q, 1'b0};

      num3_q  <= $signed({6'b0, fftt2_q}) - $signed({3'b0, pl2_2_q})
                 - $signed({3'b0, zz2_q});
      den3_q  <= den2_q;
    end
  end

  // ---------------------------------------------------------------------------------
  // Rank 4: out-of-range cosine cases, then the restoring divider for |num| / den
  // in Q28. The quotient is only used when |num| < den, so it fits in 28 bits.
  // ---------------------------------------------------------------------------------
  logic signed [38:0]    den3_s;
  logic signed [38:0]    mag3;
  kflag_t                fl_q [4:R_K];
  logic [DEN_W-1:0]      dv_r_q [0:DIV_STEPS];
  logic [DEN_W-1:0]      dv_d_q [0:DIV_STEPS];
  logic [DIV_STEPS-1:0]  dv_q_q [0:DIV_STEPS];

  assign den3_s = $signed({6'b0, den3_q});
  assign mag3   = num3_q[38] ? -num3_q : num3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q[4].kzero <= (den3_q == '0) || (num3_q >= den3_s);
      fl_q[4].kpi   <= (num3_q <= -den3_s);
      fl_q[4].neg   <= num3_q[38];
      dv_r_q[0]     <= mag3[DEN_W-1:0];
      dv_d_q[0]     <= den3_q;
      dv_q_q[0]     <= '0;
      for (int r = 5; r <= R_K; r++) begin
        fl_q[r] <= fl_q[r-1];
      end
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [DEN_W:0] rem2;
    assign rem2 = {dv_r_q[j], 1'b0};
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_d_q[j+1] <= dv_d_q[j];
        if (rem2 >= {1'b0, dv_d_q[j]}) begin
          dv_r_q[j+1] <= DEN_W'(rem2 - {1'b0, dv_d_q[j]});
          dv_q_q[j+1] <= {dv_q_q[j][DIV_STEPS-2:0], 1'b1};
        end else begin
          dv_r_q[j+1] <= rem2[DEN_W-1:0];
          dv_q_q[j+1] <= {dv_q_q[j][DIV_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  // Rank R_QQ: c^2 for the sine; the quotient itself waits for the sine.
  logic [2*DIV_STEPS-1:0] qq_q;
  logic [DIV_STEPS-1:0]   qd_q [R_QQ:R_S];

  always_ff @(posedge clk_i) begin
    if (en) begin
      qq_q      <= (2*DIV_STEPS)'(dv_q_q[DIV_STEPS]) * (2*DIV_STEPS)'(dv_q_q[DIV_STEPS]);
      qd_q[R_QQ] <= dv_q_q[DIV_STEPS];
      for (int r = R_QQ + 1; r <= R_S; r++) begin
        qd_q[r] <= qd_q[r-1];
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Two digit-by-digit square roots, one result bit per rank.
  // Lane 0: planar = floor(sqrt((x^2 + y^2) * 2^16)) from rank 2.
  // Lane 1: sine   = floor(sqrt(2^56 - c^2)) from rank R_QQ.
  // The remainder always holds v - root^2.
  // ---------------------------------------------------------------------------------
  logic [SQ_VW-1:0]      sq_v      [2];
  logic [SQ_VW-1:0]      sq_rem_q  [2][1:SQRT_STEPS];
  logic [SQRT_STEPS-1:0] sq_rt_q   [2][1:SQRT_STEPS];

  assign sq_v[0] = {5'b0, pl2_2_q, 16'b0};
  assign sq_v[1] = (SQ_VW'(1) << (SQ_VW - 1)) - {1'b0, qq_q};

  for (genvar l = 0; l < 2; l++) begin : g_sq
    for (genvar n = 1; n <= SQRT_STEPS; n++) begin : g_st
      localparam int B = SQRT_STEPS - n;
      logic [SQ_VW-1:0]      rem_in;
      logic [SQRT_STEPS-1:0] rt_in;
      logic [SQ_VW+1:0]      trial;
      if (n == 1) begin : g_first
        assign rem_in = sq_v[l];
        assign rt_in  = '0;
      end else begin : g_next
        assign rem_in = sq_rem_q[l][n-1];
        assign rt_in  = sq_rt_q[l][n-1];
      end
      // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
      assign trial = ((SQ_VW+2)'(rt_in) << (B + 1)) | ((SQ_VW+2)'(1) << (2 * B));
      always_ff @(posedge clk_i) begin
        if (en) begin
          if ({2'b0, rem_in} >= trial) begin
            sq_rem_q[l][n] <= rem_in - trial[SQ_VW-1:0];
            sq_rt_q[l][n]  <= rt_in | (SQRT_STEPS'(1) << B);
          end else begin
            sq_rem_q[l][n] <= rem_in;
            sq_rt_q[l][n]  <= rt_in;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Three CORDICs: yaw from rank 1, pitch from R_PL, knee from R_S.
  // ---------------------------------------------------------------------------------
  logic signed [COORD_W-1:0] zd_q [2:R_PL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      zd_q[2] <= z1_q;
      for (int r = 3; r <= R_PL; r++) begin
        zd_q[r] <= zd_q[r-1];
      end
    end
  end

  logic signed [CW-1:0]      yaw_x, yaw_y, pit_x, pit_y, kn_x, kn_y, q_s;
  logic signed [ANGLE_W-1:0] yaw_raw, pit_raw, knee_raw;

  assign yaw_x = {{(CW-COORD_W-8){x1_q[COORD_W-1]}}, x1_q, 8'b0};
  assign yaw_y = {{(CW-COORD_W-8){y1_q[COORD_W-1]}}, y1_q, 8'b0};
  assign pit_x = {{(CW-SQRT_STEPS){1'b0}}, sq_rt_q[0][SQRT_STEPS]};
  assign pit_y = {{(CW-COORD_W-8){zd_q[R_PL][COORD_W-1]}}, zd_q[R_PL], 8'b0};
  assign q_s   = {{(CW-DIV_STEPS){1'b0}}, qd_q[R_S]};
  assign kn_x  = fl_q[R_S].neg ? -q_s : q_s;
  assign kn_y  = {{(CW-SQRT_STEPS){1'b0}}, sq_rt_q[1][SQRT_STEPS]};

  leg_ik_cordic u_cordic_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (yaw_x),
    .y_i     (yaw_y),
    .angle_o (yaw_raw)
  );

  leg_ik_cordic u_cordic_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (pit_x),
    .y_i     (pit_y),
    .angle_o (pit_raw)
  );

  leg_ik_cordic u_cordic_knee (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (kn_x),
    .y_i     (kn_y),
    .angle_o (knee_raw)
  );

  // Yaw and pitch wait here until the knee is ready.
  logic signed [ANGLE_W-1:0] yd_q [R_Y+1:R_K];
  logic signed [ANGLE_W-1:0] pd_q [R_P+1:R_K];

  always_ff @(posedge clk_i) begin
    if (en) begin
      yd_q[R_Y+1] <= yaw_raw;
      pd_q[R_P+1] <= pit_raw;
      for (int r = R_Y + 2; r <= R_K; r++) begin
        yd_q[r] <= yd_q[r-1];
      end
      for (int r = R_P + 2; r <= R_K; r++) begin
        pd_q[r] <= pd_q[r-1];
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Output rank: limits, ankle and the result register. The lower limit is applied
  // before the upper one, so crossed limits give the upper limit.
  // ---------------------------------------------------------------------------------
  logic signed [ANGLE_W-1:0] yaw_d;
  logic signed [16:0]        kn_d, np_d, ank_d;
  logic signed [ANGLE_W-1:0] yaw_q, pitch_q;
  logic [KNEE_W-1:0]         knee_q;
  logic signed [ANKLE_W-1:0] ankle_q;

  always_comb begin
    yaw_d = yd_q[R_K];
    if (yaw_d < yaw_min_q) begin
      yaw_d = yaw_min_q;
    end
    if (yaw_d > yaw_max_q) begin
      yaw_d = yaw_max_q;
    end

    if (fl_q[R_K].kzero) begin
      kn_d = '0;
    end else if (fl_q[R_K].kpi) begin
      kn_d = 17'(Q13_PI);
    end else begin
      kn_d = 17'(knee_raw);
    end
    if (kn_d < 17'sd0) begin
      kn_d = '0;
    end
    if (kn_d > 17'(Q13_PI)) begin
      kn_d = 17'(Q13_PI);
    end
    if (kn_d < $signed({2'b0, knee_min_q})) begin
      kn_d = $signed({2'b0, knee_min_q});
    end
    if (kn_d > $signed({2'b0, knee_max_q})) begin
      kn_d = $signed({2'b0, knee_max_q});
    end

    // Minus half the pitch, rounded toward zero.
    np_d  = -17'(pd_q[R_K]);
    ank_d = np_d[16] ? ((np_d + 17'sd1) >>> 1) : (np_d >>> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_q   <= yaw_d;
      pitch_q <= pd_q[R_K];
      knee_q  <= kn_d[KNEE_W-1:0];
      ankle_q <= ank_d[ANKLE_W-1:0];
    end
  end

  assign jnt_o.valid       = vld_q[LAT];
  assign jnt_o.hip_yaw     = yaw_q;
  assign jnt_o.pitch_angle = pitch_q;
  assign jnt_o.knee        = knee_q;
  assign jnt_o.ankle       = ankle_q;

  // ---------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------
  logic signed [16:0] ank_sum;
  assign ank_sum = {ankle_q[ANKLE_W-1], ankle_q, 1'b0} + 17'(pitch_q);

  `LIK_ASSERT_NEXT(a_stall_freezes_pipe, clk_i, rst_ni, !en, $stable(vld_q))
  `LIK_ASSERT(a_pitch_in_range, clk_i, rst_ni,
              !jnt_o.valid || (pitch_q >= -Q13_PI && pitch_q <= Q13_PI))
  `LIK_ASSERT(a_ankle_half_pitch, clk_i, rst_ni,
              !jnt_o.valid || ank_sum == 17'sd0 || ank_sum == 17'sd1 || ank_sum == -17'sd1)
  `LIK_ASSERT_NEXT(a_accept_enters_rank1, clk_i, rst_ni,
                   tgt_i.valid && tgt_i.ready, vld_q[1])

endmodule
`default_nettype wire
